// ===== src/text_command_line_parser_unit_defines.svh =====
// Assertion macros for the command line parser unit.
`ifndef TEXT_COMMAND_LINE_PARSER_UNIT_DEFINES_SVH
`define TEXT_COMMAND_LINE_PARSER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define TCLP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define TCLP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/tclp_pkg.sv =====
// Shared types, constants and the syntax table of the command line parser.
`default_nettype none
package tclp_pkg;

	localparam int ARG_A_WIDTH = 16;
	localparam int OUT_A_WIDTH = 16;

	localparam int ROM_LEN = 18;
	localparam logic [4:0] POS_IDLE = 5'd31;

	localparam logic [7:0] SLOT_RGB = 8'd1;
	localparam logic [7:0] SLOT_A = 8'd2;
	localparam logic [7:0] SLOT_B = 8'd3;
	localparam logic [7:0] SLOT_MAX = 8'd5;

	localparam logic [7:0] CHAR_LF = 8'h0A;
	localparam logic [7:0] CHAR_CR = 8'h0D;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_0 = 8'h30;
	localparam logic [7:0] CHAR_9 = 8'h39;
	localparam logic [7:0] CHAR_UA = 8'h41;
	localparam logic [7:0] CHAR_UF = 8'h46;

	localparam logic [2:0] HEX_RED_DONE = 3'd2;
	localparam logic [2:0] HEX_GREEN_DONE = 3'd4;
	localparam logic [2:0] HEX_BLUE_DONE = 3'd6;

	localparam logic STATUS_DONE = 1'b0;
	localparam logic STATUS_UNKNOWN = 1'b1;

	typedef logic [ARG_A_WIDTH-1:0] arg_t;

	localparam logic [7:0] SYNTAX_ROM [ROM_LEN] = '{
		8'h69,
		8'h61, SLOT_RGB,
		8'h73, SLOT_A, SLOT_RGB,
		8'h74, SLOT_A,
		8'h62, SLOT_A,
		8'h63, SLOT_A, SLOT_B,
		8'h72, SLOT_A,
		8'h77, SLOT_A,
		8'h70
	};

	typedef struct packed {
		logic status;
		logic [7:0] command;
		logic [OUT_A_WIDTH-1:0] arg_a;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} result_t;

	typedef struct packed {
		logic hit;
		logic [4:0] pos;
	} lookup_t;

	typedef struct packed {
		logic ok;
		logic [3:0] value;
	} digit_t;

	// First command letter in the table that equals c; slot codes never match.
	function automatic lookup_t find_command(input logic [7:0] c);
		lookup_t r;
		r.hit = 1'b0;
		r.pos = POS_IDLE;
		for (int i = ROM_LEN - 1; i >= 0; i--) begin
			if (SYNTAX_ROM[i] > SLOT_MAX && SYNTAX_ROM[i] == c) begin
				r.hit = 1'b1;
				r.pos = 5'(i + 1);
			end
		end
		return r;
	endfunction

	function automatic digit_t hex_digit(input logic [7:0] c);
		digit_t r;
		r.ok = 1'b0;
		r.value = 4'd0;
		if (c >= CHAR_0 && c <= CHAR_9) begin
			r.ok = 1'b1;
			r.value = c[3:0];
		end else if (c >= CHAR_UA && c <= CHAR_UF) begin
			r.ok = 1'b1;
			r.value = 4'(c[2:0] + 4'd9);
		end
		return r;
	endfunction

	function automatic logic [OUT_A_WIDTH-1:0] arg_to_out(input arg_t a);
		logic [ARG_A_WIDTH+OUT_A_WIDTH-1:0] w;
		w = {{OUT_A_WIDTH{1'b0}}, a};
		return w[OUT_A_WIDTH-1:0];
	endfunction

endpackage
`default_nettype wire

// ===== src/text_command_line_parser_unit.sv =====
// Single-letter command line parser: one character per beat, one result per line or unknown letter.
//
//  channel | beat                        | flow
//  in      | char_in                     | in_valid / in_stall
//  out     | status command arg_a r g b  | out_valid / out_stall
//
// One character is taken every cycle that in_valid is high and in_stall low; its
// result, if any, goes to the output register, or to the skid stage when held.
// The output register and a one-beat skid stage hold results while out_stall
// is high; in_stall rises only when the skid stage is full.
// arst_n clears the parser to idle with all parse fields zero; output data is not reset.
`default_nettype none
`include "text_command_line_parser_unit_defines.svh"

module text_command_line_parser_unit (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] char_in,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic            status,
	output logic [7:0]      command,
	output logic [15:0]     arg_a,
	output logic [7:0]      red,
	output logic [7:0]      green,
	output logic [7:0]      blue
);

	logic [4:0] pos_q, pos_n;
	logic [2:0] hex_cnt_q, hex_cnt_n;
	logic [7:0] partial_q, partial_n;
	logic [7:0] cmd_q, cmd_n;
	tclp_pkg::arg_t arg_q, arg_n;
	logic [7:0] red_q, red_n;
	logic [7:0] green_q, green_n;
	logic [7:0] blue_q, blue_n;

	tclp_pkg::result_t res;
	logic res_valid;
	tclp_pkg::result_t out_q, skid_q;
	logic out_valid_q, skid_valid_q;

	logic accept, res_fire, out_free;
	tclp_pkg::lookup_t lk;
	tclp_pkg::digit_t hx;
	logic [7:0] slot;
	logic [3:0] dec;

	assign in_stall = skid_valid_q;
	assign accept = in_valid && !skid_valid_q;
	assign res_fire = accept && res_valid;
	assign out_free = !out_valid_q || !out_stall;

	assign lk = tclp_pkg::find_command(char_in);
	assign hx = tclp_pkg::hex_digit(char_in);
	assign dec = char_in[3:0];
	assign slot = (pos_q < 5'(tclp_pkg::ROM_LEN)) ? tclp_pkg::SYNTAX_ROM[pos_q] : 8'd0;

	always_comb begin
		pos_n = pos_q;
		hex_cnt_n = hex_cnt_q;
		partial_n = partial_q;
		cmd_n = cmd_q;
		arg_n = arg_q;
		red_n = red_q;
		green_n = green_q;
		blue_n = blue_q;
		res_valid = 1'b0;
		res = '0;
		if (char_in == tclp_pkg::CHAR_LF || char_in == tclp_pkg::CHAR_CR) begin
			if (pos_q != tclp_pkg::POS_IDLE) begin
				res_valid = 1'b1;
				res.status = tclp_pkg::STATUS_DONE;
				res.command = cmd_q;
				res.arg_a = tclp_pkg::arg_to_out(arg_q);
				res.red = red_q;
				res.green = green_q;
				res.blue = blue_q;
				pos_n = tclp_pkg::POS_IDLE;
			end
		end else if (pos_q == tclp_pkg::POS_IDLE) begin
			cmd_n = 8'd0;
			arg_n = '0;
			red_n = 8'd0;
			green_n = 8'd0;
			blue_n = 8'd0;
			hex_cnt_n = 3'd0;
			partial_n = 8'd0;
			if (lk.hit) begin
				cmd_n = char_in;
				pos_n = lk.pos;
			end else begin
				res_valid = 1'b1;
				res.status = tclp_pkg::STATUS_UNKNOWN;
				res.command = char_in;
			end
		end else if (slot == tclp_pkg::SLOT_RGB) begin
			if (!hx.ok) begin
				cmd_n = 8'd0;
				pos_n = tclp_pkg::POS_IDLE;
			end else begin
				partial_n = {partial_q[3:0], hx.value};
				hex_cnt_n = hex_cnt_q + 3'd1;
				if (hex_cnt_n == tclp_pkg::HEX_RED_DONE) begin
					red_n = partial_n;
					partial_n = 8'd0;
				end else if (hex_cnt_n == tclp_pkg::HEX_GREEN_DONE) begin
					green_n = partial_n;
					partial_n = 8'd0;
				end else if (hex_cnt_n == tclp_pkg::HEX_BLUE_DONE) begin
					blue_n = partial_n;
					partial_n = 8'd0;
				end
				if (hex_cnt_n >= tclp_pkg::HEX_BLUE_DONE) begin
					pos_n = pos_q + 5'd1;
				end
			end
		end else if (slot == tclp_pkg::SLOT_A || slot == tclp_pkg::SLOT_B) begin
			if (char_in == tclp_pkg::CHAR_SPACE) begin
				pos_n = pos_q + 5'd1;
			end else if (char_in < tclp_pkg::CHAR_0 || char_in > tclp_pkg::CHAR_9) begin
				cmd_n = 8'd0;
				pos_n = tclp_pkg::POS_IDLE;
			end else if (slot == tclp_pkg::SLOT_A) begin
				arg_n = (arg_q << 3) + (arg_q << 1) + tclp_pkg::arg_t'(dec);
			end else begin
				blue_n = (blue_q << 3) + (blue_q << 1) + {4'd0, dec};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= tclp_pkg::POS_IDLE;
			hex_cnt_q <= 3'd0;
			partial_q <= 8'd0;
			cmd_q <= 8'd0;
			arg_q <= '0;
			red_q <= 8'd0;
			green_q <= 8'd0;
			blue_q <= 8'd0;
		end else if (accept) begin
			pos_q <= pos_n;
			hex_cnt_q <= hex_cnt_n;
			partial_q <= partial_n;
			cmd_q <= cmd_n;
			arg_q <= arg_n;
			red_q <= red_n;
			green_q <= green_n;
			blue_q <= blue_n;
		end
	end

	// Drain the skid stage first, else load a fresh result; park it in skid when held.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= skid_valid_q || res_fire;
			skid_valid_q <= 1'b0;
		end else if (res_fire) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (res_fire) begin
				out_q <= res;
			end
		end else if (res_fire) begin
			skid_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign status = out_q.status;
	assign command = out_q.command;
	assign arg_a = out_q.arg_a;
	assign red = out_q.red;
	assign green = out_q.green;
	assign blue = out_q.blue;

	`TCLP_ASSERT_NOW(a_skid_behind_out, skid_valid_q, out_valid_q, "skid full with output empty")
	`TCLP_ASSERT_NOW(a_pos_range, 1'b1, (pos_q <= 5'(tclp_pkg::ROM_LEN)) || (pos_q == tclp_pkg::POS_IDLE), "parse position out of range")
	`TCLP_ASSERT_NOW(a_hex_cnt_range, 1'b1, hex_cnt_q <= tclp_pkg::HEX_BLUE_DONE, "hex digit count past six")
	`TCLP_ASSERT_NEXT(a_fire_shows, res_fire && out_free && !skid_valid_q, out_valid_q, "result lost")

endmodule
`default_nettype wire
